/* hw/rtl/mab_pkg.sv */
// shared types, constants and helpers of the mesh adjacency builder
package mab_pkg;

	localparam int unsigned NODE_W         = 17;
	localparam int unsigned LEN_W          = 5;
	localparam int unsigned CORNERS        = 8;
	localparam int unsigned DEF_MAX_NODES  = 65536;
	localparam int unsigned DEF_ROW_CAP    = 26;
	localparam int unsigned FIFO_DEPTH     = 4;
	localparam int unsigned FIFO_PW        = $clog2(FIFO_DEPTH);
	localparam int unsigned PAIR_IDX_W     = 6;
	localparam logic [PAIR_IDX_W-1:0] PAIR_IDX_END = '1;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CORNERS-1:0][NODE_W-1:0] corners_t;

	typedef enum logic [1:0] {
		OP_PAIR,
		OP_INS_END,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		node_t    owner;
		node_t    nb;
		logic     ok;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic {
		FE_IDLE,
		FE_PAIRS
	} fe_state_t;

	typedef enum logic [2:0] {
		BE_CLEAR,
		BE_IDLE,
		BE_UPD,
		BE_LOAD,
		BE_EMIT
	} be_state_t;

	function automatic logic node_in_range(node_t n, int unsigned max_nodes);
		return (n != '0) && (32'(n) <= max_nodes);
	endfunction

endpackage

/* hw/rtl/mab_fifo.sv */
// short operation queue between front and back
module mab_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mab_pkg::op_t     push_op,
	input  logic             pop,
	output mab_pkg::op_t     head,
	output mab_pkg::fifo_stat_t stat
);
	import mab_pkg::*;

	op_t                 entry_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]  wr_ptr_q;
	logic [FIFO_PW-1:0]  rd_ptr_q;
	logic [FIFO_PW:0]    fill_q;
	logic                do_push;
	logic                do_pop;

	assign stat.full  = (fill_q == (FIFO_PW+1)'(FIFO_DEPTH));
	assign stat.empty = (fill_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

/* hw/rtl/mab_front.sv */
// front end: accepts items and expands inserts into corner pair operations
module mab_front #(
	parameter int unsigned MAX_NODES = mab_pkg::DEF_MAX_NODES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                func,
	input  mab_pkg::corners_t   corners,
	input  mab_pkg::node_t      query_node,
	input  mab_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output mab_pkg::op_t        push_op,
	output logic                fe_busy
);
	import mab_pkg::*;

	fe_state_t               state_q;
	fe_state_t               state_d;
	corners_t                corner_q;
	logic [PAIR_IDX_W-1:0]   pq_q;
	logic [2:0]              p_idx;
	logic [2:0]              q_idx;
	node_t                   np;
	node_t                   nq;

	assign p_idx   = pq_q[5:3];
	assign q_idx   = pq_q[2:0];
	assign np      = corner_q[p_idx];
	assign nq      = corner_q[q_idx];
	assign fe_busy = (state_q != FE_IDLE) || fifo_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			pq_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pq_q <= '0;
			end else if (state_q == FE_PAIRS && !fifo_stat.full) begin
				pq_q <= pq_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !func) begin
			corner_q <= corners;
		end
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		push_op = '0;
		unique case (state_q)
			FE_IDLE: begin
				if (accept) begin
					if (func) begin
						push          = 1'b1;
						push_op.kind  = OP_READ;
						push_op.owner = query_node;
						push_op.ok    = node_in_range(query_node, MAX_NODES);
					end else begin
						state_d = FE_PAIRS;
					end
				end
			end
			FE_PAIRS: begin
				if (!fifo_stat.full) begin
					if (pq_q == PAIR_IDX_END) begin
						push         = 1'b1;
						push_op.kind = OP_INS_END;
						state_d      = FE_IDLE;
					end else if (p_idx != q_idx && node_in_range(np, MAX_NODES)
							&& node_in_range(nq, MAX_NODES)) begin
						push          = 1'b1;
						push_op.kind  = OP_PAIR;
						push_op.owner = np;
						push_op.nb    = nq;
						push_op.ok    = 1'b1;
					end
				end
			end
			default: begin
				state_d = FE_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/mab_back.sv */
// back end: row memory, row counts, pair updates and row readout
module mab_back #(
	parameter int unsigned MAX_NODES    = mab_pkg::DEF_MAX_NODES,
	parameter int unsigned ROW_CAPACITY = mab_pkg::DEF_ROW_CAP
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mab_pkg::op_t        head,
	input  mab_pkg::fifo_stat_t fifo_stat,
	output logic                pop,
	output logic                clearing,
	output logic                result_valid,
	output mab_pkg::node_t      neighbor_node,
	output logic [mab_pkg::LEN_W-1:0] row_length,
	output logic                is_last,
	output logic                overflow_seen
);
	import mab_pkg::*;

	localparam int unsigned AW = $clog2(MAX_NODES);
	localparam int unsigned CW = $clog2(ROW_CAPACITY + 1);
	localparam int unsigned KW = $clog2(ROW_CAPACITY);
	localparam logic [AW-1:0] LAST_ROW = AW'(MAX_NODES - 1);

	typedef logic [ROW_CAPACITY-1:0][NODE_W-1:0] row_t;

	row_t              rows_mem [MAX_NODES];
	logic [CW-1:0]     cnt_mem  [MAX_NODES];

	be_state_t         state_q;
	be_state_t         state_d;
	logic [AW-1:0]     clr_q;
	op_t               op_q;
	row_t              row_rd_q;
	logic [CW-1:0]     cnt_rd_q;
	logic [KW-1:0]     k_q;
	logic              ovf_q;

	logic              rd_en;
	logic [AW-1:0]     rd_idx;
	logic [AW-1:0]     op_idx;
	logic              row_we;
	row_t              row_wr;
	logic              cnt_we;
	logic [AW-1:0]     cnt_waddr;
	logic [CW-1:0]     cnt_wdata;
	logic              hit;
	logic              ovf_set;
	logic              ovf_clr;
	logic              k_clr;
	logic              k_inc;
	logic              emit;
	node_t             emit_nb;
	logic [LEN_W-1:0]  emit_len;
	logic              emit_last;
	logic              emit_ovf;
	logic              emit_tail;

	assign rd_idx    = AW'(32'(head.owner) - 32'd1);
	assign op_idx    = AW'(32'(op_q.owner) - 32'd1);
	assign clearing  = (state_q == BE_CLEAR);
	assign emit_tail = ((CW'(k_q) + 1'b1) == cnt_rd_q);

	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < ROW_CAPACITY; k++) begin
			if ((CW'(k) < cnt_rd_q) && (row_rd_q[k] == op_q.nb)) begin
				hit = 1'b1;
			end
		end
		row_wr = row_rd_q;
		row_wr[cnt_rd_q[KW-1:0]] = op_q.nb;
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		rd_en     = 1'b0;
		row_we    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = op_idx;
		cnt_wdata = cnt_rd_q + 1'b1;
		ovf_set   = 1'b0;
		ovf_clr   = 1'b0;
		k_clr     = 1'b0;
		k_inc     = 1'b0;
		emit      = 1'b0;
		emit_nb   = '0;
		emit_len  = '0;
		emit_last = 1'b0;
		emit_ovf  = 1'b0;
		unique case (state_q)
			BE_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
				if (clr_q == LAST_ROW) begin
					state_d = BE_IDLE;
				end
			end
			BE_IDLE: begin
				if (!fifo_stat.empty) begin
					pop = 1'b1;
					unique case (head.kind)
						OP_PAIR: begin
							rd_en   = 1'b1;
							state_d = BE_UPD;
						end
						OP_INS_END: begin
							emit      = 1'b1;
							emit_last = 1'b1;
							emit_ovf  = ovf_q;
							ovf_clr   = 1'b1;
						end
						OP_READ: begin
							if (head.ok) begin
								rd_en   = 1'b1;
								state_d = BE_LOAD;
							end else begin
								emit      = 1'b1;
								emit_last = 1'b1;
							end
						end
						default: begin
							emit      = 1'b1;
							emit_last = 1'b1;
						end
					endcase
				end
			end
			BE_UPD: begin
				state_d = BE_IDLE;
				if (!hit) begin
					if (cnt_rd_q >= CW'(ROW_CAPACITY)) begin
						ovf_set = 1'b1;
					end else begin
						row_we = 1'b1;
						cnt_we = 1'b1;
					end
				end
			end
			BE_LOAD: begin
				if (cnt_rd_q == '0) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = BE_IDLE;
				end else begin
					k_clr   = 1'b1;
					state_d = BE_EMIT;
				end
			end
			BE_EMIT: begin
				emit      = 1'b1;
				emit_nb   = row_rd_q[k_q];
				emit_len  = LEN_W'(cnt_rd_q);
				emit_last = emit_tail;
				if (emit_tail) begin
					state_d = BE_IDLE;
				end else begin
					k_inc = 1'b1;
				end
			end
			default: begin
				state_d = BE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BE_CLEAR;
			clr_q        <= '0;
			ovf_q        <= 1'b0;
			k_q          <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit;
			if (state_q == BE_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ovf_set) begin
				ovf_q <= 1'b1;
			end else if (ovf_clr) begin
				ovf_q <= 1'b0;
			end
			if (k_clr) begin
				k_q <= '0;
			end else if (k_inc) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		if (emit) begin
			neighbor_node <= emit_nb;
			row_length    <= emit_len;
			is_last       <= emit_last;
			overflow_seen <= emit_ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_rd_q <= rows_mem[rd_idx];
		end
		if (row_we) begin
			rows_mem[op_idx] <= row_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cnt_rd_q <= cnt_mem[rd_idx];
		end
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
	end

	a_upd_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BE_UPD) |=> (state_q == BE_IDLE))
		else $error("pair update did not return to idle");

	a_emit_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BE_EMIT) |-> (CW'(k_q) < cnt_rd_q))
		else $error("readout index beyond row count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (cnt_wdata <= CW'(ROW_CAPACITY)))
		else $error("row count above capacity");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && overflow_seen) |-> is_last)
		else $error("overflow flag on a non-final result");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop && !result_valid)
		else $error("activity during count clearing");

endmodule

/* hw/rtl/mesh_adjacency_builder_core.sv */
// top level of the mesh adjacency builder
//
// command channel: an item is taken at a clock edge with start high and busy low.
// func 0 inserts one hexahedral element (corner_a..corner_h), func 1 reads the
// row of query_node. each result sits on the result ports for one cycle with
// result_valid high; the receiver must take it then.
// an insert is expanded by the front end into up to 56 corner pair updates; the
// back end handles each pair as a registered row read, then a compare against
// all stored entries and a write back of a new neighbour, so an insert holds the
// back end for its valid pairs and then gives its single result. a read returns
// one result per stored entry, or one result for an empty row or a bad node.
// a four-entry operation queue lets the front accept the next item while the
// back end is still working; busy rises when the front is expanding or the
// queue is full. results follow the input order.
// after reset the row count memory is cleared one row per cycle, all MAX_NODES
// rows of it, and busy stays high until that pass ends.
module mesh_adjacency_builder_core #(
	parameter int unsigned MAX_NODES    = mab_pkg::DEF_MAX_NODES,
	parameter int unsigned ROW_CAPACITY = mab_pkg::DEF_ROW_CAP
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       func,
	input  mab_pkg::node_t             corner_a,
	input  mab_pkg::node_t             corner_b,
	input  mab_pkg::node_t             corner_c,
	input  mab_pkg::node_t             corner_d,
	input  mab_pkg::node_t             corner_e,
	input  mab_pkg::node_t             corner_f,
	input  mab_pkg::node_t             corner_g,
	input  mab_pkg::node_t             corner_h,
	input  mab_pkg::node_t             query_node,
	output logic                       result_valid,
	output mab_pkg::node_t             neighbor_node,
	output logic [mab_pkg::LEN_W-1:0]  row_length,
	output logic                       is_last,
	output logic                       overflow_seen
);
	import mab_pkg::*;

	logic       accept;
	logic       fe_busy;
	logic       clearing;
	logic       push;
	logic       pop;
	op_t        push_op;
	op_t        head;
	fifo_stat_t fifo_stat;
	corners_t   corners;

	assign corners = {corner_h, corner_g, corner_f, corner_e,
		corner_d, corner_c, corner_b, corner_a};
	assign busy    = fe_busy || clearing;
	assign accept  = start && !busy;

	mab_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.func       (func),
		.corners    (corners),
		.query_node (query_node),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_op    (push_op),
		.fe_busy    (fe_busy)
	);

	mab_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.stat    (fifo_stat)
	);

	mab_back #(
		.MAX_NODES    (MAX_NODES),
		.ROW_CAPACITY (ROW_CAPACITY)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.fifo_stat     (fifo_stat),
		.pop           (pop),
		.clearing      (clearing),
		.result_valid  (result_valid),
		.neighbor_node (neighbor_node),
		.row_length    (row_length),
		.is_last       (is_last),
		.overflow_seen (overflow_seen)
	);

endmodule
